[rtl/kped_pkg.sv]
// shared types, codes and defaults for the key press event detector
package kped_pkg;

  // gap timer width default
  localparam int GAP_TIMER_BITS_DEF = 16;

  // register byte addresses
  localparam logic [3:0] ADDR_LONG_PRESS  = 4'h0;
  localparam logic [3:0] ADDR_REPEAT      = 4'h4;
  localparam logic [3:0] ADDR_CLICK_GAP   = 4'h8;
  localparam logic [3:0] ADDR_CONFIRM     = 4'hc;

  // register reset values
  localparam logic [15:0] LONG_PRESS_RST = 16'd100;
  localparam logic [15:0] REPEAT_RST     = 16'd20;
  localparam logic [15:0] CLICK_GAP_RST  = 16'd30;
  localparam logic [3:0]  CONFIRM_RST    = 4'd2;

  // phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_PRESS    = 3'd2;
  localparam logic [2:0] PH_LONG     = 3'd3;
  localparam logic [2:0] PH_KEEP     = 3'd4;
  localparam logic [2:0] PH_RELEASE  = 3'd5;
  localparam logic [2:0] PH_RECORD   = 3'd6;

  // event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_DOWN      = 3'd1;
  localparam logic [2:0] EV_LONG      = 3'd2;
  localparam logic [2:0] EV_KEEP      = 3'd3;
  localparam logic [2:0] EV_UP        = 3'd4;
  localparam logic [2:0] EV_MULTI     = 3'd5;
  localparam logic [2:0] EV_CLICKOVER = 3'd6;

  // press class codes
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_SHORT = 2'd1;
  localparam logic [1:0] CLS_LONG  = 2'd2;
  localparam logic [1:0] CLS_KEEP  = 2'd3;

  // saturation limit of the 4-bit counters
  localparam logic [3:0] CNT_MAX = 4'hf;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [15:0] repeat_ticks;
    logic [15:0] click_gap_ticks;
    logic [3:0]  repeat_confirm_steps;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [3:0] event_key;
    logic [3:0] hold_steps;
    logic [3:0] clicks;
    logic [1:0] release_class;
  } result_t;

endpackage

[rtl/key_press_event_detector_top.sv]
// key press event detector: one input transaction per scan tick, one result each
// the result of an accepted transaction is written into the result buffer and offered from there in order
// throughput: one transaction per cycle while in_ready is high; the two-entry result buffer sets in_ready
// in_ready drops only while both result entries wait to be taken
// reset (rst_n low, synchronous): phase idle, counters cleared, gap timer saturated,
// registers to their defaults, result buffer empty
module key_press_event_detector_top #(
  parameter int GAP_TIMER_BITS = kped_pkg::GAP_TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [3:0]  out_event_key,
  output logic [3:0]  out_hold_steps,
  output logic [3:0]  out_clicks,
  output logic [1:0]  out_release_class,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kped_pkg::*;

  cfg_t    cfg;
  result_t core_res, buf_res;
  logic    tick;

  assign tick = in_valid & in_ready;

  // configuration registers
  kped_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-tick phase machine
  kped_core #(.GapBits(GAP_TIMER_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .tick     (tick),
    .key_code (in_key_code),
    .res      (core_res)
  );

  // result buffer
  kped_out_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tick),
    .wr_data  (core_res),
    .not_full (in_ready),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (buf_res)
  );

  assign out_event_kind    = buf_res.event_kind;
  assign out_event_key     = buf_res.event_key;
  assign out_hold_steps    = buf_res.hold_steps;
  assign out_clicks        = buf_res.clicks;
  assign out_release_class = buf_res.release_class;

endmodule

[rtl/kped_cfg_regs.sv]
// apb configuration registers
module kped_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output kped_pkg::cfg_t   cfg
);
  import kped_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // register writes, word index from paddr[3:2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks     <= LONG_PRESS_RST;
      cfg_r.repeat_ticks         <= REPEAT_RST;
      cfg_r.click_gap_ticks      <= CLICK_GAP_RST;
      cfg_r.repeat_confirm_steps <= CONFIRM_RST;
    end else if (wr_en) begin
      case ({paddr[3:2], 2'b00})
        ADDR_LONG_PRESS: cfg_r.long_press_ticks     <= pwdata[15:0];
        ADDR_REPEAT:     cfg_r.repeat_ticks         <= pwdata[15:0];
        ADDR_CLICK_GAP:  cfg_r.click_gap_ticks      <= pwdata[15:0];
        ADDR_CONFIRM:    cfg_r.repeat_confirm_steps <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case ({paddr[3:2], 2'b00})
      ADDR_LONG_PRESS: prdata = {16'd0, cfg_r.long_press_ticks};
      ADDR_REPEAT:     prdata = {16'd0, cfg_r.repeat_ticks};
      ADDR_CLICK_GAP:  prdata = {16'd0, cfg_r.click_gap_ticks};
      ADDR_CONFIRM:    prdata = {28'd0, cfg_r.repeat_confirm_steps};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

[rtl/kped_core.sv]
// phase machine, timers and event decode for one scan tick
module kped_core #(
  parameter int GapBits = kped_pkg::GAP_TIMER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kped_pkg::cfg_t    cfg,
  input  logic              tick,
  input  logic [3:0]        key_code,
  output kped_pkg::result_t res
);
  import kped_pkg::*;

  localparam int CW = (GapBits > 16) ? GapBits : 16;

  logic [2:0]         phase_r, phase_nxt;
  logic [3:0]         held_key_r, held_key_nxt;
  logic [15:0]        hold_timer_r, hold_timer_nxt;
  logic [3:0]         confirm_r, confirm_nxt;
  logic [3:0]         keep_r, keep_nxt;
  logic [3:0]         click_total_r, click_total_nxt;
  logic [GapBits-1:0] gap_r, gap_nxt, gap_inc;
  logic               pending_r, pending_nxt;
  logic [1:0]         class_r, class_nxt;

  logic [15:0] hold_inc;
  logic [4:0]  confirm_lim;
  logic [CW-1:0] gap_ext, gap_cfg;
  logic        key_on;

  assign key_on      = (key_code != 4'd0);
  assign hold_inc    = hold_timer_r + 16'd1;
  assign confirm_lim = {1'b0, cfg.repeat_confirm_steps} + 5'd3;
  assign gap_inc     = (&gap_r) ? gap_r : gap_r + 1'b1;
  assign gap_ext     = CW'(gap_inc);
  assign gap_cfg     = CW'(cfg.click_gap_ticks);

  // next state and event for this tick
  always_comb begin
    phase_nxt       = phase_r;
    held_key_nxt    = held_key_r;
    hold_timer_nxt  = hold_timer_r;
    confirm_nxt     = confirm_r;
    keep_nxt        = keep_r;
    click_total_nxt = click_total_r;
    gap_nxt         = gap_inc;
    pending_nxt     = pending_r;
    class_nxt       = class_r;
    res.event_kind  = EV_NONE;
    res.event_key   = 4'd0;
    res.hold_steps  = 4'd0;
    res.clicks      = 4'd0;
    case (phase_r)
      PH_DEBOUNCE: begin
        phase_nxt = PH_PRESS;
      end
      PH_PRESS: begin
        if (key_on) begin
          held_key_nxt   = key_code;
          hold_timer_nxt = 16'd0;
          res.event_kind = EV_DOWN;
          res.event_key  = key_code;
          phase_nxt      = PH_LONG;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (key_on) begin
          if (hold_inc > cfg.long_press_ticks) begin
            hold_timer_nxt = 16'd0;
            keep_nxt       = 4'd0;
            confirm_nxt    = 4'd0;
            res.event_kind = EV_LONG;
            res.event_key  = key_code;
            phase_nxt      = PH_KEEP;
            class_nxt      = CLS_LONG;
          end else begin
            hold_timer_nxt = hold_inc;
            class_nxt      = CLS_SHORT;
          end
        end else begin
          phase_nxt = PH_RELEASE;
        end
      end
      PH_KEEP: begin
        if (key_on) begin
          if (hold_inc > cfg.repeat_ticks) begin
            hold_timer_nxt = 16'd0;
            if (({1'b0, confirm_r} < confirm_lim) && (confirm_r != CNT_MAX))
              confirm_nxt = confirm_r + 4'd1;
            if ((keep_r != CNT_MAX) && (confirm_nxt > cfg.repeat_confirm_steps))
              keep_nxt = keep_r + 4'd1;
            if (keep_nxt != 4'd0) begin
              class_nxt      = CLS_KEEP;
              res.event_kind = EV_KEEP;
              res.event_key  = key_code;
              res.hold_steps = keep_nxt;
            end
          end else begin
            hold_timer_nxt = hold_inc;
          end
        end else begin
          phase_nxt = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        res.event_kind = EV_UP;
        res.event_key  = held_key_r;
        phase_nxt      = PH_RECORD;
      end
      PH_RECORD: begin
        if (gap_ext < gap_cfg) begin
          if (click_total_r != CNT_MAX) click_total_nxt = click_total_r + 4'd1;
        end else begin
          click_total_nxt = 4'd0;
        end
        if (click_total_nxt != 4'd0) begin
          pending_nxt    = 1'b1;
          res.event_kind = EV_MULTI;
          res.event_key  = held_key_r;
          res.clicks     = (click_total_nxt != CNT_MAX) ? click_total_nxt : 4'd0;
        end
        phase_nxt = PH_IDLE;
        gap_nxt   = '0;
      end
      default: begin
        // idle and the unused code
        phase_nxt = PH_IDLE;
        if (pending_r && (gap_ext > gap_cfg)) begin
          res.event_kind = EV_CLICKOVER;
          res.event_key  = held_key_r;
          pending_nxt    = 1'b0;
        end
        if (key_on) phase_nxt = PH_DEBOUNCE;
      end
    endcase
    res.release_class = class_nxt;
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      held_key_r    <= 4'd0;
      hold_timer_r  <= 16'd0;
      confirm_r     <= 4'd0;
      keep_r        <= 4'd0;
      click_total_r <= 4'd0;
      gap_r         <= '1;
      pending_r     <= 1'b0;
      class_r       <= CLS_NONE;
    end else if (tick) begin
      phase_r       <= phase_nxt;
      held_key_r    <= held_key_nxt;
      hold_timer_r  <= hold_timer_nxt;
      confirm_r     <= confirm_nxt;
      keep_r        <= keep_nxt;
      click_total_r <= click_total_nxt;
      gap_r         <= gap_nxt;
      pending_r     <= pending_nxt;
      class_r       <= class_nxt;
    end
  end

endmodule

[rtl/kped_out_buf.sv]
// two-entry result buffer between the core and the output channel
module kped_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  kped_pkg::result_t wr_data,
  output logic              not_full,
  output logic              rd_valid,
  input  logic              rd_ready,
  output kped_pkg::result_t rd_data
);
  import kped_pkg::*;

  result_t    slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       rd_en;

  assign not_full = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_en    = rd_valid & rd_ready;
  assign rd_data  = slot_r[rd_ptr_r];

  // payload slots
  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wr_ptr_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
